[hw/rtl/tcf_pkg.sv]
// constants, types and match patterns for the telnet command filter
// no dependencies; imported by telnet_command_filter
package tcf_pkg;

    localparam int SUB_LIMIT = 63;
    localparam int SUB_CNT_W = $clog2(SUB_LIMIT + 1);
    localparam logic [SUB_CNT_W-1:0] SUB_MAX = SUB_CNT_W'(SUB_LIMIT);

    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_SE   = 8'd240;

    localparam logic [7:0] OPT_ECHO  = 8'd1;
    localparam logic [7:0] OPT_SGA   = 8'd3;
    localparam logic [7:0] OPT_TTYPE = 8'd24;
    localparam logic [7:0] OPT_NAWS  = 8'd31;
    localparam logic [7:0] TT_IS     = 8'd0;
    localparam logic [7:0] TT_SEND   = 8'd1;

    localparam logic [8:0] WIDTH_RST  = 9'd80;
    localparam logic [7:0] HEIGHT_RST = 8'd24;

    localparam logic [63:0] PAT_A = "256color";
    localparam logic [71:0] PAT_B = "xterm-256";
    localparam logic [79:0] PAT_C = "screen-256";

    localparam logic [3:0] CNT_NONE  = 4'd0;
    localparam logic [3:0] CNT_DATA  = 4'd1;
    localparam logic [3:0] CNT_REPLY = 4'd3;
    localparam logic [3:0] CNT_TTYPE = 4'd9;

    typedef enum logic [1:0] {
        VERB_WILL = 2'd0,
        VERB_WONT = 2'd1,
        VERB_DO   = 2'd2,
        VERB_DONT = 2'd3
    } verb_t;

    typedef enum logic [5:0] {
        PH_NORMAL  = 6'b000001,
        PH_IAC     = 6'b000010,
        PH_VERB    = 6'b000100,
        PH_SB_OPT  = 6'b001000,
        PH_SB_DATA = 6'b010000,
        PH_SB_IAC  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [3:0] cnt;
        logic [7:0] verb;
        logic [7:0] data;
        logic [8:0] width;
        logic [7:0] height;
        logic       capable;
        logic       wide;
    } desc_t;

endpackage

[hw/rtl/telnet_command_filter.sv]
// telnet receive parser: data passthrough, option replies, NAWS and terminal type
// depends on tcf_pkg
//
// usage:
//   s_ channel carries one received byte per transfer in s_tdata
//   m_ channel carries results: m_tuser 0 = byte for the application,
//   1 = reply byte for the peer; m_tlast marks the final result of one
//   received byte; m_tdata also carries the terminal status after that byte
// path: a taken byte waits in the input register until it is parsed; its
//   results go into the result register, from which the first result is
//   offered
// throughput: one byte per cycle for plain data while m_tready stays high;
//   a negotiation reply holds the result register for 3 beats, a DO
//   TERMINAL-TYPE reply for 9 beats; meanwhile one byte waits in the input
//   register, and bytes that cause no result keep being parsed
// stall: a stalled receiver holds the current beat; the input register
//   fills and s_tready drops until the last beat of the current result is taken
// reset: synchronous, aresetn low; parser returns to the data phase, size
//   80 x 24, color_256 clear, no terminal type seen
module telnet_command_filter
    import tcf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_byte, term_width, term_height, ttype_seen, color_256
    output logic        m_tuser,   // out_kind
    output logic        m_tlast    // out_last
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    phase_t               phase_reg, phase_next;
    verb_t                verb_reg, verb_next;
    logic [7:0]           option_reg, option_next;
    logic [SUB_CNT_W-1:0] count_reg, count_next;
    logic [7:0]           head_reg [4];
    logic [7:0]           head_next [4];
    logic [79:0]          win_reg, win_next;
    logic                 hit_reg, hit_next;
    logic                 nul_reg, nul_next;
    logic [8:0]           width_reg, width_next;
    logic [7:0]           height_reg, height_next;
    logic                 capable_reg, capable_next;
    logic                 wide_reg, wide_next;

    desc_t                desc_reg;
    logic                 desc_valid_reg;
    logic [3:0]           beat_reg;

    logic [3:0]           res_cnt;
    logic [7:0]           res_verb;
    logic [7:0]           b;
    logic [79:0]          win_shift;
    logic                 win_hit;
    logic                 desc_free;
    logic                 process;
    logic [7:0]           beat_byte;

    assign b         = in_byte_reg;
    assign win_shift = {win_reg[71:0], b};
    assign win_hit   = (win_shift[63:0] == PAT_A) || (win_shift[71:0] == PAT_B)
                    || (win_shift == PAT_C);

    always_comb begin
        phase_next   = phase_reg;
        verb_next    = verb_reg;
        option_next  = option_reg;
        count_next   = count_reg;
        head_next    = head_reg;
        win_next     = win_reg;
        hit_next     = hit_reg;
        nul_next     = nul_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        capable_next = capable_reg;
        wide_next    = wide_reg;
        res_cnt      = CNT_NONE;
        res_verb     = B_WONT;
        unique case (phase_reg)
            PH_IAC: begin
                phase_next = PH_NORMAL;
                if (b == B_IAC) begin
                    res_cnt = CNT_DATA;
                end else if (b >= B_WILL && b <= B_DONT) begin
                    verb_next  = verb_t'(2'(b - B_WILL));
                    phase_next = PH_VERB;
                end else if (b == B_SB) begin
                    phase_next = PH_SB_OPT;
                end
            end
            PH_VERB: begin
                phase_next = PH_NORMAL;
                res_cnt    = CNT_REPLY;
                unique case (verb_reg)
                    VERB_DO: begin
                        if (b == OPT_SGA || b == OPT_NAWS) begin
                            res_verb = B_WILL;
                        end else if (b == OPT_TTYPE) begin
                            res_verb = B_WILL;
                            res_cnt  = CNT_TTYPE;
                        end else begin
                            res_verb = B_WONT;
                        end
                    end
                    VERB_DONT: res_verb = B_WONT;
                    VERB_WILL: res_verb = (b == OPT_ECHO || b == OPT_SGA) ? B_DO : B_DONT;
                    VERB_WONT: res_verb = B_DONT;
                    default:   res_verb = B_DONT;
                endcase
            end
            PH_SB_OPT: begin
                option_next = b;
                count_next  = '0;
                head_next   = '{default: 8'd0};
                win_next    = '0;
                hit_next    = 1'b0;
                nul_next    = 1'b0;
                phase_next  = PH_SB_DATA;
            end
            PH_SB_DATA: begin
                if (b == B_IAC) begin
                    phase_next = PH_SB_IAC;
                end else if (count_reg < SUB_MAX) begin
                    if (count_reg < SUB_CNT_W'(4)) begin
                        head_next[count_reg[1:0]] = b;
                    end
                    if (count_reg != '0 && !nul_reg) begin
                        if (b == 8'd0) begin
                            nul_next = 1'b1;
                        end else begin
                            win_next = win_shift;
                            if (win_hit) begin
                                hit_next = 1'b1;
                            end
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            PH_SB_IAC: begin
                phase_next = PH_NORMAL;
                if (b == B_SE) begin
                    if (option_reg == OPT_NAWS) begin
                        if (count_reg >= SUB_CNT_W'(4)) begin
                            if (head_reg[0][7:1] == 7'd0
                                    && {head_reg[0][0], head_reg[1]} != 9'd0) begin
                                width_next = {head_reg[0][0], head_reg[1]};
                            end
                            if (head_reg[2] == 8'd0 && head_reg[3] != 8'd0) begin
                                height_next = head_reg[3];
                            end
                        end
                    end else if (option_reg == OPT_TTYPE) begin
                        if (count_reg > SUB_CNT_W'(1) && head_reg[0] == TT_IS) begin
                            capable_next = 1'b1;
                            if (hit_reg) begin
                                wide_next = 1'b1;
                            end
                        end
                    end
                end else if (b == B_IAC) begin
                    phase_next = PH_IAC;
                end else begin
                    res_cnt = CNT_DATA;
                end
            end
            default: begin
                phase_next = PH_NORMAL;
                if (b == B_IAC) begin
                    phase_next = PH_IAC;
                end else begin
                    res_cnt = CNT_DATA;
                end
            end
        endcase
    end

    assign desc_free = !desc_valid_reg || (m_tready && m_tlast);
    assign process   = in_valid_reg && (res_cnt == CNT_NONE || desc_free);
    assign s_tready  = !in_valid_reg || process;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (process) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_NORMAL;
            verb_reg    <= VERB_WILL;
            option_reg  <= 8'd0;
            count_reg   <= '0;
            head_reg    <= '{default: 8'd0};
            win_reg     <= '0;
            hit_reg     <= 1'b0;
            nul_reg     <= 1'b0;
            width_reg   <= WIDTH_RST;
            height_reg  <= HEIGHT_RST;
            capable_reg <= 1'b0;
            wide_reg    <= 1'b0;
        end else if (process) begin
            phase_reg   <= phase_next;
            verb_reg    <= verb_next;
            option_reg  <= option_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            win_reg     <= win_next;
            hit_reg     <= hit_next;
            nul_reg     <= nul_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            capable_reg <= capable_next;
            wide_reg    <= wide_next;
        end
    end

    // result register: one descriptor per byte that yields a result, drained one beat per transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            desc_valid_reg <= 1'b0;
            beat_reg       <= 4'd0;
        end else if (process && res_cnt != CNT_NONE) begin
            desc_valid_reg <= 1'b1;
            beat_reg       <= 4'd0;
        end else if (m_tvalid && m_tready) begin
            if (m_tlast) begin
                desc_valid_reg <= 1'b0;
            end else begin
                beat_reg <= beat_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (process && res_cnt != CNT_NONE) begin
            desc_reg.cnt     <= res_cnt;
            desc_reg.verb    <= res_verb;
            desc_reg.data    <= b;
            desc_reg.width   <= width_reg;
            desc_reg.height  <= height_reg;
            desc_reg.capable <= capable_reg;
            desc_reg.wide    <= wide_reg;
        end
    end

    always_comb begin
        if (desc_reg.cnt == CNT_DATA) begin
            beat_byte = desc_reg.data;
        end else begin
            unique case (beat_reg)
                4'd0:    beat_byte = B_IAC;
                4'd1:    beat_byte = desc_reg.verb;
                4'd2:    beat_byte = desc_reg.data;
                4'd3:    beat_byte = B_IAC;
                4'd4:    beat_byte = B_SB;
                4'd5:    beat_byte = OPT_TTYPE;
                4'd6:    beat_byte = TT_SEND;
                4'd7:    beat_byte = B_IAC;
                4'd8:    beat_byte = B_SE;
                default: beat_byte = B_IAC;
            endcase
        end
    end

    assign m_tvalid = desc_valid_reg;
    assign m_tuser  = (desc_reg.cnt != CNT_DATA);
    assign m_tlast  = (beat_reg == desc_reg.cnt - 4'd1);
    assign m_tdata  = {5'd0, desc_reg.wide, desc_reg.capable, desc_reg.height,
                       desc_reg.width, beat_byte};

    a_desc_count: assert property (@(posedge aclk) disable iff (!aresetn)
        desc_valid_reg |-> (desc_reg.cnt == CNT_DATA || desc_reg.cnt == CNT_REPLY
                            || desc_reg.cnt == CNT_TTYPE))
        else $error("result descriptor with bad beat count");

    a_beat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        desc_valid_reg |-> (beat_reg < desc_reg.cnt))
        else $error("beat index past descriptor count");

    a_beat_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && beat_reg == $past(beat_reg) + 4'd1))
        else $error("reply burst broken before its last beat");

    a_data_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("application byte not a single-beat transfer");

    a_sub_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= SUB_MAX)
        else $error("subnegotiation count above limit");

endmodule
